// ----- design/sit_pkg.sv -----
// Shared constants for the segment intersection test unit.
package sit_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int TOL_W              = 16;
    localparam logic [TOL_W-1:0] TOLERANCE_RESET = 16'd1;

endpackage

// ----- design/sit_if.sv -----
// Handshake channels: segment pair in, intersection flag out.
interface sit_pair_if #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg2_start_x;
    logic signed [COORD_BITS-1:0] seg2_start_y;
    logic signed [COORD_BITS-1:0] seg2_end_x;
    logic signed [COORD_BITS-1:0] seg2_end_y;

    modport source (
        output valid,
        output seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
        output seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
        input  seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        output ready
    );
endinterface

interface sit_result_if;
    logic valid;
    logic ready;
    logic intersects;

    modport source (
        output valid,
        output intersects,
        input  ready
    );

    modport sink (
        input  valid,
        input  intersects,
        output ready
    );
endinterface

// ----- design/segment_intersection_test_unit.sv -----
// Top level: pipelined line segment intersection test.
//
//  channel          dir  width                 content
//  pairs            in   8 x COORD_BITS       two segments, endpoint coordinates
//  verdicts         out  1                    intersects
//  tolerance_wr_*   in   16                   collinearity / betweenness epsilon
//
//  One pair per cycle unless a verdict stall fills the pipeline; four register stages, in order:
//  differences, products, cross/dot sums, compares into the output register.
//  Reset clears all stage valid bits and sets the tolerance to 1.
//  A stall holds each full stage; bubbles are squeezed out, so pairs keep
//  entering until every stage is full.
module segment_intersection_test_unit #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tolerance_wr_en,
    input  logic [sit_pkg::TOL_W-1:0]  tolerance_wr_data,
    sit_pair_if.sink                   pairs,
    sit_result_if.source               verdicts
);

    localparam int DW     = COORD_BITS + 1;
    localparam int PW     = 2 * DW;
    localparam int SW     = PW + 1;
    localparam int CMP_W  = (SW > sit_pkg::TOL_W + 1) ? SW : sit_pkg::TOL_W + 2;

    // difference vector codes
    localparam logic [2:0] D_BA = 3'd0;   // b - a
    localparam logic [2:0] D_DC = 3'd1;   // d - c
    localparam logic [2:0] D_CA = 3'd2;   // c - a
    localparam logic [2:0] D_DA = 3'd3;   // d - a
    localparam logic [2:0] D_CB = 3'd4;   // c - b
    localparam logic [2:0] D_DB = 3'd5;   // d - b
    localparam logic [2:0] D_BC = 3'd6;   // b - c
    localparam logic [2:0] D_AC = 3'd7;   // a - c

    // cross k: u x v ; dot k: u . v
    localparam logic [2:0] CROSS_U [4] = '{D_BA, D_BA, D_DC, D_DC};
    localparam logic [2:0] CROSS_V [4] = '{D_DA, D_CA, D_BC, D_AC};
    localparam logic [2:0] DOT_U   [4] = '{D_CA, D_CB, D_AC, D_DA};
    localparam logic [2:0] DOT_V   [4] = '{D_DA, D_DB, D_BC, D_DB};

    function automatic logic signed [DW-1:0] diff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        logic signed [DW-1:0] pe;
        logic signed [DW-1:0] qe;
        pe = DW'(p);
        qe = DW'(q);
        return pe - qe;
    endfunction

    logic [sit_pkg::TOL_W-1:0] tol_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [DW-1:0] dx_next [8];
    logic signed [DW-1:0] dy_next [8];
    logic signed [DW-1:0] dx_reg  [8];
    logic signed [DW-1:0] dy_reg  [8];

    logic signed [PW-1:0] cl_next [4];
    logic signed [PW-1:0] cr_next [4];
    logic signed [PW-1:0] dl_next [4];
    logic signed [PW-1:0] dr_next [4];
    logic signed [PW-1:0] cl_reg  [4];
    logic signed [PW-1:0] cr_reg  [4];
    logic signed [PW-1:0] dl_reg  [4];
    logic signed [PW-1:0] dr_reg  [4];

    logic signed [SW-1:0] cross_next [4];
    logic signed [SW-1:0] dot_next   [4];
    logic signed [SW-1:0] cross_reg  [4];
    logic signed [SW-1:0] dot_reg    [4];

    logic intersects_next;
    logic intersects_reg;

    // ready chain
    assign rdy4 = !v4_reg || verdicts.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign pairs.ready         = rdy1;
    assign verdicts.valid      = v4_reg;
    assign verdicts.intersects = intersects_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= sit_pkg::TOLERANCE_RESET;
        end
        else if (tolerance_wr_en)
        begin
            tol_reg <= tolerance_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= pairs.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: differences
    always_comb
    begin
        dx_next[D_BA] = diff(pairs.seg1_end_x,   pairs.seg1_start_x);
        dy_next[D_BA] = diff(pairs.seg1_end_y,   pairs.seg1_start_y);
        dx_next[D_DC] = diff(pairs.seg2_end_x,   pairs.seg2_start_x);
        dy_next[D_DC] = diff(pairs.seg2_end_y,   pairs.seg2_start_y);
        dx_next[D_CA] = diff(pairs.seg2_start_x, pairs.seg1_start_x);
        dy_next[D_CA] = diff(pairs.seg2_start_y, pairs.seg1_start_y);
        dx_next[D_DA] = diff(pairs.seg2_end_x,   pairs.seg1_start_x);
        dy_next[D_DA] = diff(pairs.seg2_end_y,   pairs.seg1_start_y);
        dx_next[D_CB] = diff(pairs.seg2_start_x, pairs.seg1_end_x);
        dy_next[D_CB] = diff(pairs.seg2_start_y, pairs.seg1_end_y);
        dx_next[D_DB] = diff(pairs.seg2_end_x,   pairs.seg1_end_x);
        dy_next[D_DB] = diff(pairs.seg2_end_y,   pairs.seg1_end_y);
        dx_next[D_BC] = diff(pairs.seg1_end_x,   pairs.seg2_start_x);
        dy_next[D_BC] = diff(pairs.seg1_end_y,   pairs.seg2_start_y);
        dx_next[D_AC] = diff(pairs.seg1_start_x, pairs.seg2_start_x);
        dy_next[D_AC] = diff(pairs.seg1_start_y, pairs.seg2_start_y);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pairs.valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // stage 2: products
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cl_next[k] = PW'(dx_reg[CROSS_U[k]]) * PW'(dy_reg[CROSS_V[k]]);
            cr_next[k] = PW'(dx_reg[CROSS_V[k]]) * PW'(dy_reg[CROSS_U[k]]);
            dl_next[k] = PW'(dx_reg[DOT_U[k]])   * PW'(dx_reg[DOT_V[k]]);
            dr_next[k] = PW'(dy_reg[DOT_U[k]])   * PW'(dy_reg[DOT_V[k]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            cl_reg <= cl_next;
            cr_reg <= cr_next;
            dl_reg <= dl_next;
            dr_reg <= dr_next;
        end
    end

    // stage 3: cross and dot sums
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cross_next[k] = SW'(cl_reg[k]) - SW'(cr_reg[k]);
            dot_next[k]   = SW'(dl_reg[k]) + SW'(dr_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            cross_reg <= cross_next;
            dot_reg   <= dot_next;
        end
    end

    // stage 4: sign tests and tolerance compares
    always_comb
    begin
        logic signed [CMP_W-1:0] tol_pos;
        logic signed [CMP_W-1:0] tol_neg;
        logic signed [CMP_W-1:0] ce;
        logic signed [CMP_W-1:0] de;
        logic [3:0] neg;
        logic [3:0] pos;
        logic touch;
        logic crosses;

        tol_pos = signed'({{(CMP_W - sit_pkg::TOL_W){1'b0}}, tol_reg});
        tol_neg = -tol_pos;
        touch   = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            neg[k] = cross_reg[k][SW-1];
            pos[k] = !cross_reg[k][SW-1] && (cross_reg[k] != '0);
            // dot k pairs with cross 3-k: same point against the same segment
            ce = CMP_W'(cross_reg[3 - k]);
            de = CMP_W'(dot_reg[k]);
            touch = touch || ((ce < tol_pos) && (ce > tol_neg) && (de < tol_pos));
        end
        crosses = ((neg[0] && pos[1]) || (pos[0] && neg[1])) &&
                  ((neg[2] && pos[3]) || (pos[2] && neg[3]));
        intersects_next = crosses || touch;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            intersects_reg <= intersects_next;
        end
    end

    // pairs are refused only when every stage holds a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !pairs.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input refused with a bubble in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pairs.valid && pairs.ready) |=> v1_reg)
        else $error("accepted beat did not reach stage one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(cl_reg[0]) && $stable(dl_reg[0])))
        else $error("stalled product stage lost or changed its beat");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for segment_intersection_test_unit: directed and random segment pairs.
module tb_top;

    localparam int CB         = sit_pkg::COORD_BITS_DEFAULT;
    localparam int TW         = sit_pkg::TOL_W;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic signed [CB-1:0] seg1_start_x;
        logic signed [CB-1:0] seg1_start_y;
        logic signed [CB-1:0] seg1_end_x;
        logic signed [CB-1:0] seg1_end_y;
        logic signed [CB-1:0] seg2_start_x;
        logic signed [CB-1:0] seg2_start_y;
        logic signed [CB-1:0] seg2_end_x;
        logic signed [CB-1:0] seg2_end_y;
    } seg_pair_t;

    logic          clk;
    logic          rst_n;
    logic          tolerance_wr_en;
    logic [TW-1:0] tolerance_wr_data;

    sit_pair_if #(.COORD_BITS(CB)) pair_ch();
    sit_result_if                  verdict_ch();

    segment_intersection_test_unit #(.COORD_BITS(CB)) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .tolerance_wr_en   (tolerance_wr_en),
        .tolerance_wr_data (tolerance_wr_data),
        .pairs             (pair_ch),
        .verdicts          (verdict_ch)
    );

    logic [TW-1:0] tolerance_now;
    bit            expected_verdicts[$];
    int            mismatch_count;
    int            send_idle_pct;
    int            sink_idle_pct;
    int            stalled_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ---------------- predictor ----------------

    function automatic longint turn_of(longint ox, oy, ax, ay, bx, by);
        return (ax - ox) * (by - oy) - (bx - ox) * (ay - oy);
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit point_on_segment(longint ax, ay, bx, by, px, py, longint tol);
        longint c;
        longint d;
        c = turn_of(ax, ay, bx, by, px, py);
        d = (ax - px) * (bx - px) + (ay - py) * (by - py);
        return (c < tol) && (-tol < c) && (d < tol);
    endfunction

    function automatic bit segments_meet(seg_pair_t p, logic [TW-1:0] tol_bits);
        longint ax, ay, bx, by, cx, cy, dx, dy, tol;
        int     s1, s2, s3, s4;
        bit     crossing;
        bit     touching;
        ax  = p.seg1_start_x;
        ay  = p.seg1_start_y;
        bx  = p.seg1_end_x;
        by  = p.seg1_end_y;
        cx  = p.seg2_start_x;
        cy  = p.seg2_start_y;
        dx  = p.seg2_end_x;
        dy  = p.seg2_end_y;
        tol = tol_bits;
        s1 = sign_of(turn_of(ax, ay, bx, by, dx, dy));
        s2 = sign_of(turn_of(ax, ay, bx, by, cx, cy));
        s3 = sign_of(turn_of(cx, cy, dx, dy, bx, by));
        s4 = sign_of(turn_of(cx, cy, dx, dy, ax, ay));
        crossing = (s1 * s2 < 0) && (s3 * s4 < 0);
        touching = point_on_segment(cx, cy, dx, dy, ax, ay, tol) ||
                   point_on_segment(cx, cy, dx, dy, bx, by, tol) ||
                   point_on_segment(ax, ay, bx, by, cx, cy, tol) ||
                   point_on_segment(ax, ay, bx, by, dx, dy, tol);
        return crossing || touching;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic seg_pair_t mk(int x0, y0, x1, y1, x2, y2, x3, y3);
        seg_pair_t p;
        p.seg1_start_x = CB'(x0);
        p.seg1_start_y = CB'(y0);
        p.seg1_end_x   = CB'(x1);
        p.seg1_end_y   = CB'(y1);
        p.seg2_start_x = CB'(x2);
        p.seg2_start_y = CB'(y2);
        p.seg2_end_x   = CB'(x3);
        p.seg2_end_y   = CB'(y3);
        return p;
    endfunction

    function automatic int coord_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int corner_coord();
        int corners[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        return corners[$urandom_range(6)];
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int        bx, by, ux, uy, r;
        int        k[4];
        case ($urandom_range(5))
            0: p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
            1: p = mk(coord_in(-8, 8), coord_in(-8, 8), coord_in(-8, 8), coord_in(-8, 8),
                      coord_in(-8, 8), coord_in(-8, 8), coord_in(-8, 8), coord_in(-8, 8));
            2:
            begin
                r = ($urandom_range(1) == 0) ? 50 : 32767;
                p = mk(coord_in(-r, r), coord_in(-r, r), coord_in(-r, r), coord_in(-r, r),
                       coord_in(-r, r), coord_in(-r, r), coord_in(-r, r), coord_in(-r, r));
                if ($urandom_range(1) == 0)
                begin
                    p.seg2_start_x = p.seg1_start_x;
                    p.seg2_start_y = p.seg1_start_y;
                end
                else
                begin
                    p.seg2_end_x = p.seg1_end_x;
                    p.seg2_end_y = p.seg1_end_y;
                end
            end
            3:
            begin
                // all four ends on one line
                bx = coord_in(-1000, 1000);
                by = coord_in(-1000, 1000);
                ux = coord_in(-4, 4);
                uy = coord_in(-4, 4);
                foreach (k[i])
                    k[i] = coord_in(-20, 20);
                p = mk(bx + k[0] * ux, by + k[0] * uy, bx + k[1] * ux, by + k[1] * uy,
                       bx + k[2] * ux, by + k[2] * uy, bx + k[3] * ux, by + k[3] * uy);
            end
            4:
            begin
                p = mk(coord_in(-20, 20), coord_in(-20, 20), coord_in(-20, 20),
                       coord_in(-20, 20), coord_in(-20, 20), coord_in(-20, 20),
                       coord_in(-20, 20), coord_in(-20, 20));
                r = $urandom_range(2);
                if (r != 1)
                begin
                    p.seg1_end_x = p.seg1_start_x;
                    p.seg1_end_y = p.seg1_start_y;
                end
                if (r != 0)
                begin
                    p.seg2_end_x = p.seg2_start_x;
                    p.seg2_end_y = p.seg2_start_y;
                end
            end
            default: p = mk(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                            corner_coord(), corner_coord(), corner_coord(), corner_coord());
        endcase
        return p;
    endfunction

    // Entered just after a rising edge; leaves valid high after the accepting edge.
    task automatic send_pair(seg_pair_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_ch.valid = 1'b0;
            @(negedge clk);
        end
        pair_ch.valid        = 1'b1;
        pair_ch.seg1_start_x = p.seg1_start_x;
        pair_ch.seg1_start_y = p.seg1_start_y;
        pair_ch.seg1_end_x   = p.seg1_end_x;
        pair_ch.seg1_end_y   = p.seg1_end_y;
        pair_ch.seg2_start_x = p.seg2_start_x;
        pair_ch.seg2_start_y = p.seg2_start_y;
        pair_ch.seg2_end_x   = p.seg2_end_x;
        pair_ch.seg2_end_y   = p.seg2_end_y;
        do
            @(posedge clk);
        while (!pair_ch.ready);
        expected_verdicts = {expected_verdicts, segments_meet(p, tolerance_now)};
    endtask

    task automatic drain_verdicts();
        @(negedge clk);
        pair_ch.valid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_tolerance(logic [TW-1:0] value);
        @(negedge clk);
        tolerance_wr_en   = 1'b1;
        tolerance_wr_data = value;
        @(negedge clk);
        tolerance_wr_en   = 1'b0;
        tolerance_now     = value;
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_tolerance();
        send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(mk(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(mk(0, 0, 10, 0, 5, 1, 5, 7));
        send_pair(mk(0, 0, 10, 0, 4, 0, 20, 0));
        send_pair(mk(0, 0, 10, 0, 11, 0, 20, 0));
        send_pair(mk(3, 4, 9, -2, 9, -2, 15, 30));
        send_pair(mk(5, 0, 5, 0, 0, 0, 10, 0));
        send_pair(mk(5, 1, 5, 1, 0, 0, 10, 0));
        send_pair(mk(7, 7, 7, 7, 7, 7, 7, 7));
        send_pair(mk(7, 7, 7, 7, 8, 7, 8, 7));
        send_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(mk(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32767));
        send_pair(mk(-1, -1, -1, -1, 0, 0, 0, 0));
        drain_verdicts();
    endtask

    task automatic test_zero_tolerance();
        set_tolerance('0);
        send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(mk(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(mk(3, 4, 9, -2, 9, -2, 15, 30));
        send_pair(mk(7, 7, 7, 7, 7, 7, 7, 7));
        send_pair(mk(0, 0, 10, 0, 4, 0, 20, 0));
        drain_verdicts();
    endtask

    task automatic test_max_tolerance();
        set_tolerance('1);
        send_pair(mk(0, 0, 10, 0, 5, 1, 5, 7));
        send_pair(mk(0, 0, 0, 0, 200, 0, 200, 0));
        send_pair(mk(0, 0, 0, 0, 300, 0, 300, 0));
        send_pair(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
        drain_verdicts();
    endtask

    task automatic test_random_traffic();
        logic [TW-1:0] settings[6];
        settings[0] = sit_pkg::TOLERANCE_RESET;
        settings[1] = '0;
        settings[2] = '1;
        settings[3] = TW'($urandom_range(2, 64));
        settings[4] = TW'($urandom);
        settings[5] = sit_pkg::TOLERANCE_RESET;
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            if (chunk < 2)
            begin
                send_idle_pct = 20;
                sink_idle_pct = 74;
            end
            else if (chunk < 4)
            begin
                send_idle_pct = 74;
                sink_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                sink_idle_pct = 0;
            end
            set_tolerance(settings[chunk]);
            repeat (140)
            begin
                send_pair(random_pair());
                if ($urandom_range(99) == 0)
                    drain_verdicts();
            end
            drain_verdicts();
        end
    endtask

    // ---------------- result side ----------------

    initial
    begin
        verdict_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            verdict_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("intersects: no verdict expected, actual %0b", verdict_ch.intersects);
                mismatch_count++;
            end
            else if (verdict_ch.intersects !== expected_verdicts[0])
            begin
                $error("intersects: expected %0b, actual %0b",
                       expected_verdicts[0], verdict_ch.intersects);
                mismatch_count++;
                void'(expected_verdicts.pop_front());
            end
            else
            begin
                void'(expected_verdicts.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pair_ch.valid && pair_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n                = 1'b0;
        tolerance_wr_en      = 1'b0;
        tolerance_wr_data    = '0;
        pair_ch.valid        = 1'b0;
        pair_ch.seg1_start_x = '0;
        pair_ch.seg1_start_y = '0;
        pair_ch.seg1_end_x   = '0;
        pair_ch.seg1_end_y   = '0;
        pair_ch.seg2_start_x = '0;
        pair_ch.seg2_start_y = '0;
        pair_ch.seg2_end_x   = '0;
        pair_ch.seg2_end_y   = '0;
        tolerance_now        = sit_pkg::TOLERANCE_RESET;
        mismatch_count       = 0;
        stalled_cycles       = 0;
        send_idle_pct        = 20;
        sink_idle_pct        = 74;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_tolerance();
        test_zero_tolerance();
        test_max_tolerance();
        test_random_traffic();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
